// File: design/lte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lte_pkg
// Shared types, character codes and the escape sequence table of the
// terminal line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package lte_pkg;

    typedef enum logic [3:0] {
        OP_BELL      = 4'd0,
        OP_ECHO_WR   = 4'd1,
        OP_BS        = 4'd2,
        OP_DEL       = 4'd3,
        OP_LEFT      = 4'd4,
        OP_RIGHT     = 4'd5,
        OP_FETCH     = 4'd6,
        OP_EMPTY     = 4'd7,
        OP_NOT_READY = 4'd8
    } cmd_op_t;

    typedef enum logic [1:0] {
        KIND_ECHO      = 2'd0,
        KIND_LINE      = 2'd1,
        KIND_EMPTY     = 2'd2,
        KIND_NOT_READY = 2'd3
    } kind_t;

    // command passed from front to back end
    typedef struct packed {
        cmd_op_t     op;
        logic [6:0]  data;
    } cmd_head_t;

    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_ESC      = 8'h1b;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TWO      = 8'h32;
    localparam logic [7:0] CH_THREE    = 8'h33;
    localparam logic [7:0] CH_FIVE     = 8'h35;
    localparam logic [7:0] CH_SIX      = 8'h36;
    localparam logic [7:0] CH_RIGHT    = 8'h43;
    localparam logic [7:0] CH_LEFT     = 8'h44;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [6:0] BELL_CODE   = 7'h07;

    // escape table layout: left, save, erase, restore, right
    localparam logic [3:0] ROM_LEFT        = 4'd0;
    localparam logic [3:0] ROM_LEFT_END    = 4'd2;
    localparam logic [3:0] ROM_SAVE        = 4'd3;
    localparam logic [3:0] ROM_ERASE_END   = 4'd9;
    localparam logic [3:0] ROM_RESTORE     = 4'd10;
    localparam logic [3:0] ROM_RESTORE_END = 4'd12;
    localparam logic [3:0] ROM_RIGHT       = 4'd13;
    localparam logic [3:0] ROM_RIGHT_END   = 4'd15;

    function automatic logic [6:0] esc_byte(input logic [3:0] idx);
        logic [6:0] b;
        case (idx)
            4'd0:    b = 7'h1b;
            4'd1:    b = 7'h5b;
            4'd2:    b = 7'h44;
            4'd3:    b = 7'h1b;
            4'd4:    b = 7'h5b;
            4'd5:    b = 7'h73;
            4'd6:    b = 7'h1b;
            4'd7:    b = 7'h5b;
            4'd8:    b = 7'h30;
            4'd9:    b = 7'h4b;
            4'd10:   b = 7'h1b;
            4'd11:   b = 7'h5b;
            4'd12:   b = 7'h75;
            4'd13:   b = 7'h1b;
            4'd14:   b = 7'h5b;
            4'd15:   b = 7'h43;
            default: b = 7'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: design/lte_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lte_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/lte_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lte_fifo
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module lte_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW:0]      wr_ptr_reg;
    logic [AW:0]      wr_ptr_next;
    logic [AW:0]      rd_ptr_reg;
    logic [AW:0]      rd_ptr_next;

    assign full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                   (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign pop_data = mem_reg[rd_ptr_reg[AW-1:0]];

    assign wr_ptr_next = (push && !full) ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = (pop && !empty) ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/lte_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lte_front
// Input decoder: tracks escape mode, cursor and text length, and turns each
// input transaction into at most one command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lte_front #(
    parameter int LINE_CHARS = 32,
    localparam int IW = $clog2(LINE_CHARS)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,
    input  wire logic                s_tuser,
    input  wire logic                q_full,
    output logic                     q_push,
    output lte_pkg::cmd_head_t       q_head,
    output logic      [IW-1:0]       q_start,
    output logic      [IW-1:0]       q_len
);

    typedef enum logic [4:0] {
        MODE_RUNNING = 5'b00001,
        MODE_ESC     = 5'b00010,
        MODE_SBO     = 5'b00100,
        MODE_TILDE   = 5'b01000,
        MODE_FULL    = 5'b10000
    } mode_t;

    localparam logic [IW-1:0] LAST_POS = IW'(LINE_CHARS - 1);

    mode_t         mode_reg;
    mode_t         mode_next;
    logic [IW-1:0] cursor_reg;
    logic [IW-1:0] cursor_next;
    logic [IW-1:0] len_reg;
    logic [IW-1:0] len_next;
    logic          accept;
    logic          printable;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign printable = !s_tdata[7] && (s_tdata >= lte_pkg::CH_SPACE);

    always_comb
    begin
        mode_next    = mode_reg;
        cursor_next  = cursor_reg;
        len_next     = len_reg;
        q_push       = 1'b0;
        q_head.op    = lte_pkg::OP_BELL;
        q_head.data  = lte_pkg::BELL_CODE;
        q_start      = cursor_reg;
        q_len        = len_reg;
        if (accept)
        begin
            if (s_tuser)
            begin
                q_push = 1'b1;
                if (mode_reg != MODE_FULL)
                begin
                    q_head.op = lte_pkg::OP_NOT_READY;
                end
                else
                begin
                    q_head.op   = (len_reg == '0) ? lte_pkg::OP_EMPTY : lte_pkg::OP_FETCH;
                    q_start     = '0;
                    len_next    = '0;
                    cursor_next = '0;
                    mode_next   = MODE_RUNNING;
                end
            end
            else
            begin
                case (mode_reg)
                    MODE_RUNNING:
                    begin
                        if (s_tdata == lte_pkg::CH_BS)
                        begin
                            q_push = 1'b1;
                            if (cursor_reg != '0)
                            begin
                                q_head.op   = lte_pkg::OP_BS;
                                cursor_next = cursor_reg - 1'b1;
                                len_next    = len_reg - 1'b1;
                            end
                        end
                        else if (s_tdata == lte_pkg::CH_ESC)
                        begin
                            mode_next = MODE_ESC;
                        end
                        else if (s_tdata == lte_pkg::CH_CR || s_tdata == lte_pkg::CH_LF)
                        begin
                            mode_next = MODE_FULL;
                        end
                        else if (printable)
                        begin
                            q_push = 1'b1;
                            if (cursor_reg != LAST_POS)
                            begin
                                q_head.op   = lte_pkg::OP_ECHO_WR;
                                q_head.data = s_tdata[6:0];
                                cursor_next = cursor_reg + 1'b1;
                                if (cursor_reg == len_reg)
                                begin
                                    len_next = len_reg + 1'b1;
                                end
                            end
                        end
                    end
                    MODE_ESC:
                    begin
                        mode_next = (s_tdata == lte_pkg::CH_LBRACKET) ? MODE_SBO : MODE_RUNNING;
                    end
                    MODE_SBO:
                    begin
                        mode_next = MODE_RUNNING;
                        if (s_tdata == lte_pkg::CH_RIGHT)
                        begin
                            q_push = 1'b1;
                            if (cursor_reg < len_reg && cursor_reg != LAST_POS)
                            begin
                                q_head.op   = lte_pkg::OP_RIGHT;
                                cursor_next = cursor_reg + 1'b1;
                            end
                        end
                        else if (s_tdata == lte_pkg::CH_LEFT)
                        begin
                            q_push = 1'b1;
                            if (cursor_reg != '0)
                            begin
                                q_head.op   = lte_pkg::OP_LEFT;
                                cursor_next = cursor_reg - 1'b1;
                            end
                        end
                        else if (s_tdata == lte_pkg::CH_THREE)
                        begin
                            q_push    = 1'b1;
                            mode_next = MODE_TILDE;
                            if (cursor_reg < len_reg)
                            begin
                                q_head.op = lte_pkg::OP_DEL;
                                q_start   = cursor_reg + 1'b1;
                                len_next  = len_reg - 1'b1;
                            end
                        end
                        else if (s_tdata == lte_pkg::CH_TWO || s_tdata == lte_pkg::CH_FIVE ||
                                 s_tdata == lte_pkg::CH_SIX)
                        begin
                            mode_next = MODE_TILDE;
                        end
                    end
                    MODE_TILDE:
                    begin
                        mode_next = MODE_RUNNING;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RUNNING;
            cursor_reg <= '0;
            len_reg    <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            cursor_reg <= cursor_next;
            len_reg    <= len_next;
        end
    end

endmodule

`default_nettype wire

// File: design/lte_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lte_back
// Command executor: owns the line store RAM, plays out escape sequences,
// echoes and moves text one byte per cycle while the output is not stalled,
// and drives the output register.
`default_nettype none

module lte_back #(
    parameter int LINE_CHARS = 32,
    localparam int IW = $clog2(LINE_CHARS)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    output logic                     q_pop,
    input  wire lte_pkg::cmd_head_t  q_head,
    input  wire logic [IW-1:0]       q_start,
    input  wire logic [IW-1:0]       q_len,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [7:0]          m_tdata,
    output logic      [1:0]          m_tuser,
    output logic                     m_tlast
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PRE    = 5'b00010,
        ST_TXT_RD = 5'b00100,
        ST_TXT    = 5'b01000,
        ST_POST   = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    lte_pkg::cmd_op_t  op_reg;
    lte_pkg::cmd_op_t  op_next;
    logic [IW-1:0]     idx_reg;
    logic [IW-1:0]     idx_next;
    logic [IW-1:0]     len_reg;
    logic [IW-1:0]     len_next;
    logic [3:0]        rom_reg;
    logic [3:0]        rom_next;
    logic [3:0]        rom_end_reg;
    logic [3:0]        rom_end_next;
    logic [IW-1:0]     idx_plus;

    logic              out_valid_reg;
    logic              out_valid_next;
    lte_pkg::kind_t    out_kind_reg;
    logic [6:0]        out_data_reg;
    logic              out_last_reg;

    logic              load;
    logic              emit;
    lte_pkg::kind_t    e_kind;
    logic [6:0]        e_data;
    logic              e_last;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [6:0]        wr_data;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic [6:0]        rd_data;
    logic              is_fetch;
    logic              is_edit;
    logic              txt_end;

    lte_ram #(
        .WIDTH (7),
        .DEPTH (LINE_CHARS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign load     = !out_valid_reg || m_tready;
    assign idx_plus = idx_reg + 1'b1;
    assign is_fetch = (op_reg == lte_pkg::OP_FETCH);
    assign is_edit  = (op_reg == lte_pkg::OP_BS) || (op_reg == lte_pkg::OP_DEL);
    assign txt_end  = (idx_plus == len_reg);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        rom_next     = rom_reg;
        rom_end_next = rom_end_reg;
        q_pop        = 1'b0;
        emit         = 1'b0;
        e_kind       = lte_pkg::KIND_ECHO;
        e_data       = '0;
        e_last       = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = idx_reg - 1'b1;
        wr_data      = rd_data;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && load)
                begin
                    q_pop    = 1'b1;
                    op_next  = q_head.op;
                    idx_next = q_start;
                    len_next = q_len;
                    case (q_head.op)
                        lte_pkg::OP_BELL:
                        begin
                            emit   = 1'b1;
                            e_data = lte_pkg::BELL_CODE;
                            e_last = 1'b1;
                        end
                        lte_pkg::OP_ECHO_WR:
                        begin
                            emit    = 1'b1;
                            e_data  = q_head.data;
                            e_last  = 1'b1;
                            wr_en   = 1'b1;
                            wr_addr = q_start;
                            wr_data = q_head.data;
                        end
                        lte_pkg::OP_EMPTY:
                        begin
                            emit   = 1'b1;
                            e_kind = lte_pkg::KIND_EMPTY;
                            e_last = 1'b1;
                        end
                        lte_pkg::OP_NOT_READY:
                        begin
                            emit   = 1'b1;
                            e_kind = lte_pkg::KIND_NOT_READY;
                            e_last = 1'b1;
                        end
                        lte_pkg::OP_LEFT:
                        begin
                            rom_next     = lte_pkg::ROM_LEFT;
                            rom_end_next = lte_pkg::ROM_LEFT_END;
                            state_next   = ST_PRE;
                        end
                        lte_pkg::OP_RIGHT:
                        begin
                            rom_next     = lte_pkg::ROM_RIGHT;
                            rom_end_next = lte_pkg::ROM_RIGHT_END;
                            state_next   = ST_PRE;
                        end
                        lte_pkg::OP_BS:
                        begin
                            rom_next     = lte_pkg::ROM_LEFT;
                            rom_end_next = lte_pkg::ROM_ERASE_END;
                            state_next   = ST_PRE;
                        end
                        lte_pkg::OP_DEL:
                        begin
                            rom_next     = lte_pkg::ROM_SAVE;
                            rom_end_next = lte_pkg::ROM_ERASE_END;
                            state_next   = ST_PRE;
                        end
                        lte_pkg::OP_FETCH:
                        begin
                            state_next = ST_TXT_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PRE:
            begin
                if (load)
                begin
                    emit     = 1'b1;
                    e_data   = lte_pkg::esc_byte(rom_reg);
                    e_last   = (rom_reg == rom_end_reg) && !is_edit;
                    rom_next = rom_reg + 1'b1;
                    if (rom_reg == rom_end_reg)
                    begin
                        if (!is_edit)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (idx_reg < len_reg)
                        begin
                            state_next = ST_TXT_RD;
                        end
                        else
                        begin
                            rom_next   = lte_pkg::ROM_RESTORE;
                            state_next = ST_POST;
                        end
                    end
                end
            end
            ST_TXT_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_TXT;
            end
            ST_TXT:
            begin
                if (load)
                begin
                    emit     = 1'b1;
                    e_kind   = is_fetch ? lte_pkg::KIND_LINE : lte_pkg::KIND_ECHO;
                    e_data   = rd_data;
                    e_last   = is_fetch && txt_end;
                    wr_en    = !is_fetch;
                    idx_next = idx_plus;
                    if (!txt_end)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_plus;
                    end
                    else if (is_fetch)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rom_next   = lte_pkg::ROM_RESTORE;
                        state_next = ST_POST;
                    end
                end
            end
            ST_POST:
            begin
                if (load)
                begin
                    emit     = 1'b1;
                    e_data   = lte_pkg::esc_byte(rom_reg);
                    e_last   = (rom_reg == lte_pkg::ROM_RESTORE_END);
                    rom_next = rom_reg + 1'b1;
                    if (rom_reg == lte_pkg::ROM_RESTORE_END)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        idx_reg     <= idx_next;
        len_reg     <= len_next;
        rom_reg     <= rom_next;
        rom_end_reg <= rom_end_next;
        if (load && emit)
        begin
            out_kind_reg <= e_kind;
            out_data_reg <= e_data;
            out_last_reg <= e_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: design/terminal_line_editor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_line_editor_top
// Console line editor with VT100 echo: decoder front end, command queue,
// executor back end with the line store RAM.
//
//   channel  dir  signals                        payload
//   s_*      in   tvalid tready tdata tuser      tdata=char_code, tuser=func
//   m_*      out  tvalid tready tdata tuser tlast tdata=data_byte, tuser=kind
//
// Front end takes one transaction per cycle while the queue has room.
// Back end: single-byte results are emitted directly, cursor moves play escape
// sequences, edits also rewrite the text, and a fetch reads it, 1 RAM read per
// byte. Reset clears mode, cursor and text length; the RAM is not swept, the text
// length alone marks entries valid. Output stalls hold the back end only.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_line_editor_top #(
    parameter int LINE_CHARS  = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_code
    input  wire logic       s_tuser,   // [0] func
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [6:0] data_byte, [7] zero
    output logic      [1:0] m_tuser,   // [1:0] kind
    output logic            m_tlast
);

    localparam int IW = $clog2(LINE_CHARS);
    localparam int QW = $bits(lte_pkg::cmd_head_t) + 2 * IW;

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    lte_pkg::cmd_head_t f_head;
    logic [IW-1:0]      f_start;
    logic [IW-1:0]      f_len;
    lte_pkg::cmd_head_t b_head;
    logic [IW-1:0]      b_start;
    logic [IW-1:0]      b_len;
    logic [QW-1:0]      q_in;
    logic [QW-1:0]      q_out;

    lte_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_head   (f_head),
        .q_start  (f_start),
        .q_len    (f_len)
    );

    assign q_in = {f_head, f_start, f_len};

    lte_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign {b_head, b_start, b_len} = q_out;

    lte_back #(
        .LINE_CHARS (LINE_CHARS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_head   (b_head),
        .q_start  (b_start),
        .q_len    (b_len),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
